### rtl/core/lapy_pkg.sv
// Shared constants, types and the arctangent table for the look-at pitch/yaw pipeline.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lapy_pkg;

    // Number of CORDIC micro-rotations (default of the top-level parameter)
    localparam int LAPY_CORDIC_STEPS = 16;

    // Square root of a 64-bit radicand resolves one result bit per step
    localparam int SQRT_STEPS = 32;

    // CORDIC operand width; magnitudes below 2^32 prescaled by 2^24 plus gain headroom
    localparam int CW          = 64;
    localparam int PRESCALE_SH = 24;

    // Angles: accumulator Q4.30, result Q4.16
    localparam int ANG_W  = 20;
    localparam int ANG_SH = 14;
    localparam int ZW     = ANG_W + ANG_SH;

    localparam logic signed [ZW-1:0]    ROUND_BIAS   = ZW'(1 << (ANG_SH - 1));
    localparam logic signed [ANG_W-1:0] HALF_PI_Q16  = 20'sd102944;
    localparam logic signed [ANG_W-1:0] PI_Q16       = 20'sd205887;

    typedef struct packed {
        logic upd;
        logic dx_zero;
        logic dx_neg;
        logic dy_zero;
        logic dy_neg;
        logic dz_zero;
        logic dz_neg;
    } flags_t;

    typedef struct packed {
        flags_t      flags;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
    } side_t;

    // atan(2^-i) in Q2.30, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            24: v = 34'sd64;
            25: v = 34'sd32;
            26: v = 34'sd16;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            30: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/core/lapy_isqrt.sv
// Pipelined floor square root of a 64-bit radicand, one result bit per stage.
// Depends on lapy_pkg (SQRT_STEPS); stages advance together on en.
`timescale 1ns / 1ps
`default_nettype none

module lapy_isqrt
    import lapy_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [63:0] n_in,
    output logic      [31:0] root_out
);

    logic [63:0] rem_reg  [SQRT_STEPS-1];
    logic [63:0] root_reg [SQRT_STEPS-1];
    logic [31:0] root_out_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);

        logic [63:0] rem_cur, root_cur, trial, rem_nxt, root_nxt;

        if (k == 0) begin : g_first
            assign rem_cur  = n_in;
            assign root_cur = '0;
        end else begin : g_rest
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
        end

        assign trial = root_cur + BIT;

        always_comb begin
            if (rem_cur >= trial) begin
                rem_nxt  = rem_cur - trial;
                root_nxt = (root_cur >> 1) + BIT;
            end else begin
                rem_nxt  = rem_cur;
                root_nxt = root_cur >> 1;
            end
        end

        if (k < SQRT_STEPS - 1) begin : g_reg
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= rem_nxt;
                    root_reg[k] <= root_nxt;
                end
            end
        end else begin : g_last
            always_ff @(posedge aclk) begin
                if (en) begin
                    root_out_reg <= root_nxt[31:0];
                end
            end
        end
    end

    assign root_out = root_out_reg;

endmodule

`default_nettype wire

### rtl/core/lapy_cordic.sv
// Pipelined vectoring CORDIC: atan(y/x) for nonnegative magnitudes, Q4.30 angle out.
// Depends on lapy_pkg (widths, prescale, arctangent table); one rotation per stage.
`timescale 1ns / 1ps
`default_nettype none

module lapy_cordic
    import lapy_pkg::*;
#(
    parameter int STEPS = LAPY_CORDIC_STEPS
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic        [31:0]   x_in,
    input  wire logic        [31:0]   y_in,
    output logic signed      [ZW-1:0] z_out
);

    logic signed [CW-1:0] x_reg [STEPS-1];
    logic signed [CW-1:0] y_reg [STEPS-1];
    logic signed [ZW-1:0] z_reg [STEPS-1];
    logic signed [ZW-1:0] z_out_reg;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [CW-1:0] x_cur, y_cur, x_nxt, y_nxt;
        logic signed [ZW-1:0] z_cur, z_nxt;

        if (i == 0) begin : g_first
            assign x_cur = {{(CW - 32 - PRESCALE_SH){1'b0}}, x_in, {PRESCALE_SH{1'b0}}};
            assign y_cur = {{(CW - 32 - PRESCALE_SH){1'b0}}, y_in, {PRESCALE_SH{1'b0}}};
            assign z_cur = '0;
        end else begin : g_rest
            assign x_cur = x_reg[i-1];
            assign y_cur = y_reg[i-1];
            assign z_cur = z_reg[i-1];
        end

        // rotate toward the x axis; shifts floor like the arithmetic shift
        always_comb begin
            if (!y_cur[CW-1]) begin
                x_nxt = x_cur + (y_cur >>> i);
                y_nxt = y_cur - (x_cur >>> i);
                z_nxt = z_cur + atan_q30(i);
            end else begin
                x_nxt = x_cur - (y_cur >>> i);
                y_nxt = y_cur + (x_cur >>> i);
                z_nxt = z_cur - atan_q30(i);
            end
        end

        if (i < STEPS - 1) begin : g_reg
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[i] <= x_nxt;
                    y_reg[i] <= y_nxt;
                    z_reg[i] <= z_nxt;
                end
            end
        end else begin : g_last
            always_ff @(posedge aclk) begin
                if (en) begin
                    z_out_reg <= z_nxt;
                end
            end
        end
    end

    assign z_out = z_out_reg;

endmodule

`default_nettype wire

### rtl/core/look_at_pitch_yaw.sv
// Look-at pitch/yaw: offset, squares, 32-stage square root, CORDIC_STEPS-stage CORDIC, round.
// Throughput one request per cycle while the skid entry is empty; every stage is one register,
// the depth set by the square root bit steps and the CORDIC rotations. A two-entry output
// (register plus skid) keeps taking requests while a result waits. aresetn (sync, active low)
// clears valid bits.
`timescale 1ns / 1ps
`default_nettype none

module look_at_pitch_yaw
    import lapy_pkg::*;
#(
    parameter int CORDIC_STEPS = LAPY_CORDIC_STEPS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // obj_x, obj_y, obj_z, target_x, target_y, target_z (32 bits each, low to high)
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pitch_angle [19:0], yaw_angle [39:20]
    output logic      [39:0]  m_tdata,
    // updated
    output logic              m_tuser
);

    localparam int NS = 3 + SQRT_STEPS + CORDIC_STEPS + 1;

    logic          en;
    logic [NS-1:0] valid_reg;

    // ---------------- stage 0: saturated offsets ----------------
    logic signed [31:0] d_next [3];
    logic signed [31:0] d_reg  [3];
    logic               upd_next, upd0_reg;

    always_comb begin
        logic signed [32:0] diff;
        for (int a = 0; a < 3; a++) begin
            diff = {s_tdata[a*32+31], s_tdata[a*32 +: 32]}
                 - {s_tdata[(a+3)*32+31], s_tdata[(a+3)*32 +: 32]};
            if (diff[32] != diff[31]) begin
                d_next[a] = diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
                d_next[a] = diff[31:0];
            end
        end
        upd_next = (s_tdata[95:0] != s_tdata[191:96]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                d_reg[a] <= d_next[a];
            end
            upd0_reg <= upd_next;
        end
    end

    // ---------------- stage 1: magnitudes and squares ----------------
    logic [31:0] mag_next [3];
    logic [31:0] mag1_reg [3];
    logic [63:0] sqx_reg, sqz_reg;
    flags_t      flags_next, flags1_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            mag_next[a] = d_reg[a][31] ? 32'(-d_reg[a]) : 32'(d_reg[a]);
        end
        flags_next.upd     = upd0_reg;
        flags_next.dx_zero = (d_reg[0] == '0);
        flags_next.dx_neg  = d_reg[0][31];
        flags_next.dy_zero = (d_reg[1] == '0);
        flags_next.dy_neg  = d_reg[1][31];
        flags_next.dz_zero = (d_reg[2] == '0);
        flags_next.dz_neg  = d_reg[2][31];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                mag1_reg[a] <= mag_next[a];
            end
            sqx_reg    <= 64'(mag_next[0]) * 64'(mag_next[0]);
            sqz_reg    <= 64'(mag_next[2]) * 64'(mag_next[2]);
            flags1_reg <= flags_next;
        end
    end

    // ---------------- stage 2: radicand ----------------
    logic [63:0] n_reg;
    side_t       side2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg           <= sqx_reg + sqz_reg;
            side2_reg.flags <= flags1_reg;
            side2_reg.ax    <= mag1_reg[0];
            side2_reg.ay    <= mag1_reg[1];
            side2_reg.az    <= mag1_reg[2];
        end
    end

    // ---------------- horizontal distance ----------------
    logic [31:0] root;
    side_t       side_reg [SQRT_STEPS];

    lapy_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .n_in     (n_reg),
        .root_out (root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side2_reg;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------- arctangents ----------------
    logic signed [ZW-1:0] z_pitch, z_yaw;
    flags_t               fcord_reg [CORDIC_STEPS];

    lapy_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_pitch (
        .aclk  (aclk),
        .en    (en),
        .x_in  (root),
        .y_in  (side_reg[SQRT_STEPS-1].ay),
        .z_out (z_pitch)
    );

    lapy_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_yaw (
        .aclk  (aclk),
        .en    (en),
        .x_in  (side_reg[SQRT_STEPS-1].az),
        .y_in  (side_reg[SQRT_STEPS-1].ax),
        .z_out (z_yaw)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            fcord_reg[0] <= side_reg[SQRT_STEPS-1].flags;
            for (int k = 1; k < CORDIC_STEPS; k++) begin
                fcord_reg[k] <= fcord_reg[k-1];
            end
        end
    end

    // ---------------- round to Q4.16 ----------------
    logic signed [ZW-1:0]    zp_sum, zy_sum;
    logic signed [ANG_W-1:0] rp_reg, ry_reg;
    flags_t                  fr_reg;

    assign zp_sum = z_pitch + ROUND_BIAS;
    assign zy_sum = z_yaw + ROUND_BIAS;

    always_ff @(posedge aclk) begin
        if (en) begin
            rp_reg <= zp_sum[ZW-1:ANG_SH];
            ry_reg <= zy_sum[ZW-1:ANG_SH];
            fr_reg <= fcord_reg[CORDIC_STEPS-1];
        end
    end

    // ---------------- special cases, sign, quadrant ----------------
    logic signed [ANG_W-1:0] pitch_mag, pitch_fin, yaw_base, yaw_sgn, yaw_fin;
    logic                    yaw_neg, dz_pos;

    always_comb begin
        pitch_mag = (fr_reg.dx_zero && fr_reg.dz_zero) ? HALF_PI_Q16 : rp_reg;
        if (!fr_reg.upd || fr_reg.dy_zero) begin
            pitch_fin = '0;
        end else begin
            pitch_fin = fr_reg.dy_neg ? -pitch_mag : pitch_mag;
        end

        yaw_base = fr_reg.dz_zero ? HALF_PI_Q16 : ry_reg;
        yaw_neg  = fr_reg.dz_zero ? fr_reg.dx_neg : (fr_reg.dx_neg ^ fr_reg.dz_neg);
        if (fr_reg.dx_zero) begin
            yaw_sgn = '0;
        end else begin
            yaw_sgn = yaw_neg ? -yaw_base : yaw_base;
        end
        dz_pos  = !fr_reg.dz_zero && !fr_reg.dz_neg;
        yaw_fin = dz_pos ? yaw_sgn + PI_Q16 : yaw_sgn;
    end

    // ---------------- valid bits and output buffer ----------------
    logic                    out_valid_reg, skid_valid_reg, pipe_v;
    logic                    out_upd_reg, skid_upd_reg;
    logic signed [ANG_W-1:0] out_pitch_reg, out_yaw_reg, skid_pitch_reg, skid_yaw_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign pipe_v   = valid_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NS-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!skid_valid_reg) begin
            if (pipe_v) begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end else if (m_tready) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg) begin
            if (pipe_v && (!out_valid_reg || m_tready)) begin
                out_upd_reg   <= fr_reg.upd;
                out_pitch_reg <= pitch_fin;
                out_yaw_reg   <= yaw_fin;
            end else if (pipe_v) begin
                skid_upd_reg   <= fr_reg.upd;
                skid_pitch_reg <= pitch_fin;
                skid_yaw_reg   <= yaw_fin;
            end
        end else if (m_tready) begin
            out_upd_reg   <= skid_upd_reg;
            out_pitch_reg <= skid_pitch_reg;
            out_yaw_reg   <= skid_yaw_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_upd_reg;
    assign m_tdata  = {out_yaw_reg, out_pitch_reg};

    // ---------------- checks ----------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_no_update_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("angles nonzero for a request with target at position");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(valid_reg))
        else $error("pipeline moved while output buffer full");

endmodule

`default_nettype wire

### bench/lapy_checker.sv
// Result checker for look_at_pitch_yaw: snoops both stream channels and predicts each result.
// Angles come from its own bit-exact offset, square root and CORDIC predictor; no RTL dependency.
`timescale 1ns / 1ps

module lapy_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [191:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [39:0]  m_tdata,
    input  wire logic         m_tuser,
    output int                err_count,
    output int                pending,
    output int                n_checked,
    output int                n_still
);

    localparam longint HALF_PI = 102944;
    localparam longint PI      = 205887;

    typedef struct packed {
        logic               updated;
        logic signed [19:0] pitch;
        logic signed [19:0] yaw;
    } angles_t;

    angles_t angle_q[$];
    int      errs   = 0;
    int      checks = 0;
    int      stills = 0;

    // atan(2^-i) in Q2.30, rounded to nearest
    function automatic longint atan_step(input int i);
        case (i)
            0:  return 843314857;
            1:  return 497837829;
            2:  return 263043837;
            3:  return 133525159;
            4:  return 67021687;
            5:  return 33543516;
            6:  return 16775851;
            7:  return 8388437;
            8:  return 4194283;
            9:  return 2097149;
            default: return (i < 31) ? (longint'(1) << (30 - i)) : 0;
        endcase
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // floor square root, two radicand bits per step
    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // atan(y/x) for x > 0, y >= 0; vectoring CORDIC, Q4.16 out
    function automatic longint vec_angle(input longint x, input longint y);
        longint xs;
        longint ys;
        longint z;
        int     i;
        z = 0;
        x = x * 64'sd16777216;
        y = y * 64'sd16777216;
        for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end
        end
        return (z + 8192) >>> 14;
    endfunction

    function automatic angles_t predict_angles(input logic [191:0] req);
        longint      dx, dy, dz, r, pitch, yaw;
        logic [63:0] ax, az;
        angles_t     a;
        a = '0;
        if (req[31:0] == req[127:96] && req[63:32] == req[159:128]
                && req[95:64] == req[191:160]) begin
            return a;
        end
        dx = clamp32(longint'($signed(req[31:0]))  - longint'($signed(req[127:96])));
        dy = clamp32(longint'($signed(req[63:32])) - longint'($signed(req[159:128])));
        dz = clamp32(longint'($signed(req[95:64])) - longint'($signed(req[191:160])));
        pitch = 0;
        yaw   = 0;
        if (dy != 0) begin
            ax = magnitude(dx);
            az = magnitude(dz);
            r  = longint'(root_floor(ax * ax + az * az));
            pitch = (r == 0) ? HALF_PI : vec_angle(r, magnitude(dy));
            if (dy < 0) pitch = -pitch;
        end
        if (dx != 0) begin
            if (dz == 0) begin
                yaw = (dx > 0) ? HALF_PI : -HALF_PI;
            end else begin
                yaw = vec_angle(magnitude(dz), magnitude(dx));
                if ((dx < 0) != (dz < 0)) yaw = -yaw;
            end
        end
        if (dz > 0) yaw = yaw + PI;
        a.updated = 1'b1;
        a.pitch   = 20'(pitch);
        a.yaw     = 20'(yaw);
        return a;
    endfunction

    always @(posedge aclk) begin
        angles_t want;
        angles_t got;
        if (!aresetn) begin
            angle_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.updated = m_tuser;
                got.pitch   = m_tdata[19:0];
                got.yaw     = m_tdata[39:20];
                checks++;
                if (!got.updated) stills++;
                if (angle_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("[%0t] result %0d with no request outstanding: upd=%0b p=%0d y=%0d",
                                 $realtime, checks, got.updated, got.pitch, got.yaw);
                end else begin
                    want = angle_q.pop_front();
                    if (got != want) begin
                        errs++;
                        if (errs <= 10)
                            $display("[%0t] result %0d: exp upd=%0b p=%0d y=%0d, got upd=%0b p=%0d y=%0d",
                                     $realtime, checks, want.updated, want.pitch, want.yaw,
                                     got.updated, got.pitch, got.yaw);
                    end
                end
            end
            if (s_tvalid && s_tready) angle_q.push_back(predict_angles(s_tdata));
        end
        err_count <= errs;
        pending   <= angle_q.size();
        n_checked <= checks;
        n_still   <= stills;
    end

endmodule

### bench/tb_top.sv
// Testbench top for look_at_pitch_yaw: clock, reset, request stimulus and result-side stalls.
// Depends on the block RTL (with lapy_pkg) and on lapy_checker for prediction and comparison.
`timescale 1ns / 1ps

module tb_top;

    localparam int STEPS        = 16;
    localparam int N_RANDOM     = 550;
    localparam int LONG_HOLD    = 1200;
    localparam int HOLD_AT      = 150;
    localparam int DRAIN_CYCLES = 64;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         m_tuser;

    int err_count, pending, n_checked, n_still;
    int n_sent     = 0;
    int n_directed = 0;
    bit tx_quiet   = 1'b0;
    bit rx_quiet   = 1'b0;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    look_at_pitch_yaw #(.CORDIC_STEPS(STEPS)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lapy_checker #(.CORDIC_STEPS(STEPS)) u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .err_count (err_count),
        .pending   (pending),
        .n_checked (n_checked),
        .n_still   (n_still)
    );

    function automatic logic [191:0] pack_req(
        input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
        input logic [31:0] tx, input logic [31:0] ty, input logic [31:0] tz);
        return {tz, ty, tx, oz, oy, ox};
    endfunction

    // small signed offset of random magnitude, zero now and then
    function automatic logic [31:0] nudge();
        int k;
        logic [31:0] v;
        if ($urandom_range(0, 4) == 0) return '0;
        k = $urandom_range(0, 20);
        v = $urandom_range(0, 1 << k);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [31:0] corner_val();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return 32'd1;
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [191:0] rand_req();
        logic [31:0] o [3];
        logic [31:0] t [3];
        int sel;
        int axis;
        sel = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) o[i] = $urandom;
        if (sel < 40) begin
            for (int i = 0; i < 3; i++) t[i] = $urandom;
        end else if (sel < 75) begin
            for (int i = 0; i < 3; i++) t[i] = o[i] - nudge();
        end else if (sel < 85) begin
            t = o;
        end else if (sel < 95) begin
            for (int i = 0; i < 3; i++) begin
                o[i] = corner_val();
                t[i] = corner_val();
            end
        end else begin
            // offset on one axis only
            t    = o;
            axis = $urandom_range(0, 2);
            t[axis] = $urandom;
        end
        return pack_req(o[0], o[1], o[2], t[0], t[1], t[2]);
    endfunction

    task automatic send_req(input logic [191:0] req);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        if (n_sent == HOLD_AT) hold_req = 1'b1;
        if (n_sent % 40 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    endtask

    // result side: random stall after each result, one long hold-off to back up the pipe
    initial begin : result_sink
        int stall;
        int taken;
        stall = 0;
        taken = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                taken++;
                if (taken % 48 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
                stall = rx_quiet ? 0 : $urandom_range(0, 15);
            end
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_tready <= 1'b1;
                stall = 0;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: coincident points, vertical and axis-aligned offsets, quadrants, saturation
        send_req(pack_req(0, 0, 0, 0, 0, 0));
        send_req(pack_req(Q_MAX, Q_MIN, 32'd1, Q_MAX, Q_MIN, 32'd1));
        send_req(pack_req(0, Q_ONE, 0, 0, 0, 0));
        send_req(pack_req(0, -Q_ONE, 0, 0, 0, 0));
        send_req(pack_req(Q_ONE, 0, -Q_ONE, 0, 0, 0));
        send_req(pack_req(Q_ONE, Q_ONE, 0, 0, 0, 0));
        send_req(pack_req(-Q_ONE, Q_ONE, 0, 0, 0, 0));
        send_req(pack_req(0, Q_ONE, Q_ONE, 0, 0, 0));
        send_req(pack_req(0, -Q_ONE, -Q_ONE, 0, 0, 0));
        send_req(pack_req(0, 0, Q_ONE, 0, 0, 0));
        send_req(pack_req(3 * Q_ONE, Q_ONE, 2 * Q_ONE, 0, 0, 0));
        send_req(pack_req(-3 * Q_ONE, -Q_ONE, 2 * Q_ONE, 0, 0, 0));
        send_req(pack_req(-Q_ONE, 2 * Q_ONE, -5 * Q_ONE, 0, 0, 0));
        send_req(pack_req(Q_ONE, Q_ONE, Q_ONE, 0, 0, 0));
        send_req(pack_req(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
        send_req(pack_req(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_req(pack_req(Q_MAX, Q_MAX, Q_MAX, 0, 0, 0));
        send_req(pack_req(Q_MIN, Q_MIN, Q_MIN, 0, 0, 0));
        send_req(pack_req(Q_MAX, 32'd1, Q_MAX, Q_MIN, 0, Q_MIN));
        send_req(pack_req(32'd1, Q_MAX, 0, 0, Q_MIN, 0));
        send_req(pack_req(32'd1, 32'd1, 32'd1, 0, 0, 0));
        send_req(pack_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
        send_req(pack_req(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'h5555_5555, 32'h5555_5555));
        send_req(pack_req(32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                          32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA));
        n_directed = n_sent;

        for (int i = 0; i < N_RANDOM; i++) send_req(rand_req());
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d requests (%0d directed, %0d random), %0d results checked,",
                 n_sent, n_directed, n_sent - n_directed, n_checked);
        $display("%0d of them with coincident points; output held off once for %0d cycles.",
                 n_still, LONG_HOLD);
        if (err_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/core/lapy_pkg.sv
rtl/core/lapy_isqrt.sv
rtl/core/lapy_cordic.sv
rtl/core/look_at_pitch_yaw.sv
bench/lapy_checker.sv
bench/tb_top.sv
